// ===== rtl/dlcp_pkg.sv =====
// Shared types and constants for the digital line column point enumerator.
// Used by the register block, the serial divider and the top level.
package dlcp_pkg;

  localparam int XW     = 16;  // column coordinate
  localparam int YW     = 16;  // emitted y coordinate
  localparam int NUM_W  = 16;  // slope numerator a
  localparam int DEN_W  = 15;  // slope denominator b
  localparam int MU_W   = 32;  // lower bound mu
  localparam int OM_W   = 16;  // thickness omega
  localparam int PROD_W = 32;  // a * x
  localparam int NW     = 34;  // a*x - mu and a*x - mu - omega, signed
  localparam int MW     = NW - 1;  // dividend magnitude
  localparam int QW     = NW + 1;  // floor quotient, signed
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_SLOPE_NUM   = 2'd0;
  localparam logic [1:0] REG_SLOPE_DEN   = 2'd1;
  localparam logic [1:0] REG_LOWER_BOUND = 2'd2;
  localparam logic [1:0] REG_THICKNESS   = 2'd3;

  typedef struct packed {
    logic signed [NUM_W-1:0] slope_num;
    logic        [DEN_W-1:0] slope_den;
    logic signed [MU_W-1:0]  lower_bound;
    logic        [OM_W-1:0]  thickness;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic signed [NW-1:0] dividend;
    logic [DEN_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [QW-1:0] quot;
  } div_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_LOAD,
    ST_DIV_HI,
    ST_DIV_LO,
    ST_RANGE,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/dlcp_if.sv =====
// Valid/ready channel interfaces: column input and point output.
// Payload widths follow dlcp_pkg.
interface dlcp_col_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] column_x;

  modport source (output valid, output column_x, input ready);
  modport sink   (input valid, input column_x, output ready);
endinterface

interface dlcp_pt_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic        [15:0] point_y;
  logic               point_valid;
  logic               last_point;
  logic               truncated;

  modport source (output valid, output point_x, output point_y, output point_valid,
                  output last_point, output truncated, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_valid,
                  input last_point, input truncated, output ready);
endinterface

// ===== rtl/digital_line_column_points_core.sv =====
// Column point enumerator for an arithmetical digital straight line. For each accepted
// column x it returns, lowest y first, every y >= 0 with mu <= a*x - b*y < mu + omega,
// or a single result marked invalid and last when x < 0 or the column is empty; more
// than MAX_POINTS points are cut to the lowest MAX_POINTS, all flagged truncated. A
// column passes the setup steps ST_MUL, ST_SUB and ST_LOAD, two passes of the shared
// serial divider, one range step and then its results in turn, each held while the
// output stalls; a negative column goes straight to its one result. The input is not
// ready while a column is in work. Depends on dlcp_pkg, dlcp_if, dlcp_regs and dlcp_div.
module digital_line_column_points_core #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  dlcp_col_if.sink                     col,
  dlcp_pt_if.source                    pt,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dlcp_pkg::ADDR_W-1:0]  paddr,
  input  logic [dlcp_pkg::DATA_W-1:0]  pwdata,
  output logic [dlcp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import dlcp_pkg::*;

  localparam int YMAX = (COORD_BITS >= YW) ? (1 << YW) - 1 : (1 << COORD_BITS) - 1;
  localparam int CW   = $clog2(MAX_POINTS + 1);

  cfg_t     cfg;
  div_req_t dreq;
  div_res_t dres;

  state_t state, state_next;

  logic signed [XW-1:0]     x_reg;
  logic signed [PROD_W-1:0] prod;
  logic signed [NW-1:0]     n_hi;
  logic signed [NW-1:0]     n_lo;
  logic signed [QW-1:0]     hi_c;
  logic signed [QW-1:0]     lo_c;
  logic signed [QW-1:0]     lo1;
  logic signed [QW-1:0]     diff;
  logic [YW-1:0]            y_cur;
  logic [CW-1:0]            cnt;
  logic                     pv;
  logic                     trunc;
  logic                     emit_fire;

  logic                     ovalid;
  logic signed [XW-1:0]     ox;
  logic [YW-1:0]            oy;
  logic                     opv;
  logic                     olast;
  logic                     otrunc;

  dlcp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dlcp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .res (dres)
  );

  assign col.ready = (state == ST_IDLE);
  assign emit_fire = (state == ST_EMIT) && (!ovalid || pt.ready);
  assign lo1       = dres.quot + QW'(1);
  assign diff      = hi_c - lo_c;

  assign pt.valid       = ovalid;
  assign pt.point_x     = ox;
  assign pt.point_y     = oy;
  assign pt.point_valid = opv;
  assign pt.last_point  = olast;
  assign pt.truncated   = otrunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    dreq.start    = 1'b0;
    dreq.dividend = n_hi;
    dreq.divisor  = (cfg.slope_den == '0) ? DEN_W'(1) : cfg.slope_den;
    case (state)
      ST_IDLE: begin
        if (col.valid) begin
          state_next = col.column_x[XW-1] ? ST_EMIT : ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_SUB;
      ST_SUB:  state_next = ST_LOAD;
      ST_LOAD: begin
        dreq.start = 1'b1;
        state_next = ST_DIV_HI;
      end
      ST_DIV_HI: begin
        // chain the lower-bound division straight off the first result
        dreq.dividend = n_lo;
        if (dres.done) begin
          dreq.start = 1'b1;
          state_next = ST_DIV_LO;
        end
      end
      ST_DIV_LO: begin
        if (dres.done) begin
          state_next = ST_RANGE;
        end
      end
      ST_RANGE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire && cnt == CW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x_reg <= col.column_x;
        y_cur <= '0;
        cnt   <= CW'(1);
        pv    <= 1'b0;
        trunc <= 1'b0;
      end
      ST_MUL:  prod <= cfg.slope_num * x_reg;
      ST_SUB:  n_hi <= NW'(prod) - NW'(cfg.lower_bound);
      ST_LOAD: n_lo <= n_hi - NW'(signed'({1'b0, cfg.thickness}));
      ST_DIV_HI: begin
        if (dres.done) begin
          hi_c <= (dres.quot > QW'(YMAX)) ? QW'(YMAX) : dres.quot;
        end
      end
      ST_DIV_LO: begin
        if (dres.done) begin
          lo_c <= lo1[QW-1] ? '0 : lo1;
        end
      end
      ST_RANGE: begin
        if (diff[QW-1]) begin
          // empty column: one invalid result
          y_cur <= '0;
          cnt   <= CW'(1);
          pv    <= 1'b0;
          trunc <= 1'b0;
        end else if (diff >= QW'(MAX_POINTS)) begin
          y_cur <= lo_c[YW-1:0];
          cnt   <= CW'(MAX_POINTS);
          pv    <= 1'b1;
          trunc <= 1'b1;
        end else begin
          y_cur <= lo_c[YW-1:0];
          cnt   <= CW'(diff + QW'(1));
          pv    <= 1'b1;
          trunc <= 1'b0;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          y_cur <= y_cur + YW'(1);
          cnt   <= cnt - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // output register: holds one beat until taken, loads the next one as it leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (emit_fire) begin
      ovalid <= 1'b1;
    end else if (pt.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      ox     <= x_reg;
      oy     <= y_cur;
      opv    <= pv;
      olast  <= (cnt == CW'(1));
      otrunc <= trunc;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    col.valid && col.ready |=> !col.ready)
    else $error("column accepted while a column is still in work");

  a_more_to_come: assert property (@(posedge clk) disable iff (rst)
    pt.valid && pt.ready && !pt.last_point |-> state == ST_EMIT)
    else $error("non-final point taken with no column in work");

  a_invalid_is_single: assert property (@(posedge clk) disable iff (rst)
    pt.valid && !pt.point_valid |-> pt.last_point && !pt.truncated)
    else $error("invalid result not marked as sole result of its column");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    dres.done |-> state == ST_DIV_HI || state == ST_DIV_LO)
    else $error("divider finished outside a division step");

endmodule

// ===== rtl/dlcp_regs.sv =====
// APB-style configuration registers for the line (a, b, mu, omega).
// Depends on dlcp_pkg for the register map and cfg_t.
module dlcp_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dlcp_pkg::ADDR_W-1:0]  paddr,
  input  logic [dlcp_pkg::DATA_W-1:0]  pwdata,
  output logic [dlcp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output dlcp_pkg::cfg_t               cfg
);
  import dlcp_pkg::*;

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slope_num   <= '0;
      cfg.slope_den   <= DEN_W'(1);
      cfg.lower_bound <= '0;
      cfg.thickness   <= OM_W'(1);
    end else if (wr) begin
      case (idx)
        REG_SLOPE_NUM:   cfg.slope_num   <= pwdata[NUM_W-1:0];
        REG_SLOPE_DEN:   cfg.slope_den   <= pwdata[DEN_W-1:0];
        REG_LOWER_BOUND: cfg.lower_bound <= pwdata[MU_W-1:0];
        REG_THICKNESS:   cfg.thickness   <= pwdata[OM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SLOPE_NUM:   prdata = {{(DATA_W-NUM_W){cfg.slope_num[NUM_W-1]}}, cfg.slope_num};
      REG_SLOPE_DEN:   prdata = {{(DATA_W-DEN_W){1'b0}}, cfg.slope_den};
      REG_LOWER_BOUND: prdata = cfg.lower_bound;
      REG_THICKNESS:   prdata = {{(DATA_W-OM_W){1'b0}}, cfg.thickness};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/dlcp_div.sv =====
// Serial restoring floor divider: signed dividend by positive 15-bit divisor.
// One quotient bit per cycle, then a registered floor correction. Uses dlcp_pkg.
module dlcp_div (
  input  logic               clk,
  input  logic               rst,
  input  dlcp_pkg::div_req_t req,
  output dlcp_pkg::div_res_t res
);
  import dlcp_pkg::*;

  localparam int CNT_W = $clog2(MW + 1);

  logic [MW-1:0]    mag;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic             run;
  logic             fix;
  logic             done_r;
  logic signed [QW-1:0] quot_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;
  logic [NW-1:0]    abs_dvd;

  assign rem_sh  = {rem, mag[MW-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign ge      = rem_sh >= {1'b0, den};
  assign abs_dvd = req.dividend[NW-1] ? -req.dividend : req.dividend;
  assign res     = {done_r, quot_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      fix    <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fix;
      fix    <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
      end else if (run && cnt == CNT_W'(1)) begin
        run <= 1'b0;
        fix <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[NW-1];
      mag <= abs_dvd[MW-1:0];
      rem <= '0;
      den <= req.divisor;
      cnt <= CNT_W'(MW);
    end else if (run) begin
      // shift in the next dividend bit, keep the quotient bit in its place
      rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      mag <= {mag[MW-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
    if (fix) begin
      // round toward minus infinity for a negative dividend
      if (neg) begin
        quot_r <= -QW'(mag) - QW'(rem != '0);
      end else begin
        quot_r <= QW'(mag);
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for digital_line_column_points_core: a column-points predictor
// in a small scoreboard class, valid/ready drivers with random gaps, and an APB line setup.
// Depends on dlcp_pkg, dlcp_if and the RTL under rtl/.
module tb_top;
  import dlcp_pkg::*;

  localparam int MAX_PTS     = 64;
  localparam int Y_TOP       = 65535;
  localparam int SETTLE      = 20;
  localparam int LONG_HOLD   = 600;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 66;

  typedef struct packed {
    logic signed [15:0] x;
    logic        [15:0] y;
    logic               valid;
    logic               last;
    logic               trunc;
  } line_point_t;

  class column_points_board;
    logic signed [15:0] slope_num;
    logic        [14:0] slope_den;
    logic signed [31:0] lower_bound;
    logic        [15:0] thickness;
    line_point_t        pending_points[$];
    int                 mismatches;

    function new();
      slope_num   = '0;
      slope_den   = 15'd1;
      lower_bound = '0;
      thickness   = 16'd1;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_SLOPE_NUM:   slope_num   = value[15:0];
        REG_SLOPE_DEN:   slope_den   = value[14:0];
        REG_LOWER_BOUND: lower_bound = value;
        REG_THICKNESS:   thickness   = value[15:0];
        default: ;
      endcase
    endfunction

    function longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if (n % d != 0 && n < 0) q--;
      return q;
    endfunction

    // Work out every point of column x for the current line.
    function void note_column(logic signed [15:0] col_x);
      longint      n;
      longint      b;
      longint      y_lo;
      longint      y_hi;
      longint      cnt;
      bit          cut;
      line_point_t p;
      b    = (slope_den == 0) ? 1 : longint'(slope_den);
      n    = longint'(slope_num) * longint'(col_x) - longint'(lower_bound);
      y_lo = floor_quot(n - longint'(thickness), b) + 1;
      y_hi = floor_quot(n, b);
      if (y_lo < 0) y_lo = 0;
      if (y_hi > Y_TOP) y_hi = Y_TOP;
      p.x = col_x;
      if (col_x < 0 || y_hi < y_lo) begin
        p.y     = '0;
        p.valid = 1'b0;
        p.last  = 1'b1;
        p.trunc = 1'b0;
        pending_points = {pending_points, p};
      end else begin
        cnt = y_hi - y_lo + 1;
        cut = cnt > MAX_PTS;
        if (cut) cnt = MAX_PTS;
        for (longint i = 0; i < cnt; i++) begin
          p.y     = 16'(y_lo + i);
          p.valid = 1'b1;
          p.last  = (i == cnt - 1);
          p.trunc = cut;
          pending_points = {pending_points, p};
        end
      end
    endfunction

    function void check_point(line_point_t got);
      line_point_t want;
      if (pending_points.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected point: x=%0d y=%0d valid=%0b last=%0b trunc=%0b",
                   got.x, got.y, got.valid, got.last, got.trunc);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display({"point mismatch: expected x=%0d y=%0d valid=%0b last=%0b trunc=%0b,",
                      " got x=%0d y=%0d valid=%0b last=%0b trunc=%0b"},
                     want.x, want.y, want.valid, want.last, want.trunc,
                     got.x, got.y, got.valid, got.last, got.trunc);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  bit                  src_quiet;
  bit                  sink_quiet;
  bit                  long_hold_req;
  int                  cycle_count;
  column_points_board  board;

  dlcp_col_if col_ch ();
  dlcp_pt_if  pt_ch ();

  digital_line_column_points_core DUT (
    .clk     (clk),
    .rst     (rst),
    .col     (col_ch),
    .pt      (pt_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic program_line(input int a, input int b, input int mu, input int omega);
    write_reg(REG_SLOPE_NUM, a);
    write_reg(REG_SLOPE_DEN, b);
    write_reg(REG_LOWER_BOUND, mu);
    write_reg(REG_THICKNESS, omega);
  endtask

  task automatic send_column(input logic signed [15:0] x);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      col_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    col_ch.valid    <= 1'b1;
    col_ch.column_x <= x;
    do @(posedge clk); while (!col_ch.ready);
    board.note_column(x);
  endtask

  // Drop valid, wait for every expected point, then let the block go quiet.
  task automatic settle_out(input int extra);
    col_ch.valid <= 1'b0;
    while (board.pending_points.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Point sink: random ready gaps, plus one long hold-off on request.
  initial begin
    int hold;
    pt_ch.ready <= 1'b0;
    forever begin
      hold = sink_quiet ? 0 : $urandom_range(0, 8);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold += LONG_HOLD;
      end
      if (hold > 0) begin
        pt_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      pt_ch.ready <= 1'b1;
      do @(posedge clk); while (!(pt_ch.valid && pt_ch.ready));
    end
  end

  always @(posedge clk) begin
    if (!rst && pt_ch.valid && pt_ch.ready)
      board.check_point({pt_ch.point_x, pt_ch.point_y, pt_ch.point_valid,
                         pt_ch.last_point, pt_ch.truncated});
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("digital_line_column_points_core test failed");
    $finish;
  end

  initial begin
    int     a;
    int     b;
    int     k;
    int     bmax;
    int     omega;
    int     x0;
    int     y0;
    int     xv;
    int     sel;
    longint mu_l;
    board           = new();
    src_quiet       = 1'b0;
    sink_quiet      = 1'b0;
    long_hold_req   = 1'b0;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    col_ch.valid    <= 1'b0;
    col_ch.column_x <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Line after reset: one point at y = 0 for every non-negative column.
    send_column(16'sd0);
    send_column(16'sd32767);
    send_column(-16'sd32768);
    send_column(-16'sd1);
    settle_out(SETTLE);

    // y = x with huge thickness: 1, 64 (exactly full), then truncated columns.
    program_line(1, 1, 0, 65535);
    send_column(16'sd0);
    send_column(16'sd63);
    send_column(16'sd64);
    send_column(16'sd32767);
    settle_out(SETTLE);

    // Extreme coefficients: empty column at 0, two points at the far edge.
    program_line(-32768, 32767, 32'sh8000_0000, 65535);
    send_column(16'sd0);
    send_column(16'sd32767);
    send_column(16'sd16384);
    settle_out(SETTLE);

    program_line(32767, 1, 32'sh7fff_ffff, 1);
    send_column(16'sd32767);
    send_column(16'sd0);
    settle_out(SETTLE);

    // Zero divisor acts as one, then zero thickness empties every column.
    program_line(1, 0, 0, 3);
    send_column(16'sd10);
    settle_out(SETTLE);
    write_reg(REG_THICKNESS, 0);
    send_column(16'sd10);
    settle_out(SETTLE);

    // A column cut at the top of the y range, then one that fits below it.
    program_line(1, 1, -65530, 50);
    send_column(16'sd30);
    send_column(16'sd0);
    settle_out(SETTLE);

    for (int p = 0; p < PHASES; p++) begin
      a = $urandom_range(0, 1) ? int'($urandom_range(0, 16)) - 8
                               : int'($urandom_range(0, 65535)) - 32768;
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 20);
      bmax = 65535 / (k + 1);
      if (bmax > 32767) bmax = 32767;
      b = $urandom_range(0, 1) ? $urandom_range(1, (bmax < 16) ? bmax : 16)
                               : $urandom_range(1, bmax);
      omega = k * b + int'($urandom_range(0, b - 1));
      if (omega < 1) omega = 1;
      if (omega > 65535) omega = 65535;
      // Aim the line through (x0, y0) so that nearby columns hold points.
      x0   = $urandom_range(0, 32767);
      y0   = $urandom_range(0, 65535);
      mu_l = longint'(a) * longint'(x0) - longint'(b) * longint'(y0);
      if (mu_l > 64'sd2147483647) mu_l = 64'sd2147483647;
      if (mu_l < -64'sd2147483648) mu_l = -64'sd2147483648;
      program_line(a, b, int'(mu_l), omega);

      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      if (p == 2) long_hold_req = 1'b1;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(0, 19);
        if (sel < 15) begin
          xv = x0 + int'($urandom_range(0, 64)) - 32;
          if (xv > 32767) xv = 32767;
        end else if (sel < 18) begin
          xv = int'($urandom_range(0, 65535)) - 32768;
        end else begin
          xv = -int'($urandom_range(1, 32768));
        end
        send_column(16'(xv));
      end
      settle_out(SETTLE);
    end

    settle_out(80);
    if (board.mismatches == 0 && board.pending_points.size() == 0)
      $display("digital_line_column_points_core test passed");
    else
      $display("digital_line_column_points_core test failed");
    $finish;
  end

endmodule
